### rtl/stbl_pkg.sv
// shared constants and types for the sorted key table
package stbl_pkg;

    localparam int CAPACITY = 256;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic signed [CNT_W:0] t_bound;
    typedef logic signed [KEY_W-1:0] t_key;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SWAP_RD,
        ST_SWAP_WR_LO,
        ST_SWAP_WR_HI,
        ST_SHIFT,
        ST_INSERT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic we;
        t_idx waddr;
        t_key wdata;
        t_idx raddr;
    } t_ram_ctl;

endpackage

### rtl/sorted_table_find_swap_or_insert.sv
// sorted key table: binary search, then swap with successor or insert in order
//
// Input channel: i_valid / o_stall with i_key. One item at a time is taken;
// o_stall stays high from acceptance until the result is loaded into the
// output register. Output channel: o_valid / i_stall with found, swapped,
// position, overflow and entry_count, one result per item. A waiting result
// does not block acceptance of the next item; only loading the next result
// waits for the output register to be taken.
// Per item: the idle state takes the item; search steps follow (one ram read
// each, up to log2(CAPACITY)+1 steps; skipped on an empty table); then the
// swap states (read successor, write low, write high) or the shift and insert
// states, or neither on a match with no successor or a full table; last, the
// done state loads the result. Worst case: insert at index 0 into 255 entries.
// The table lives in one ram with one read and one write port; the shift
// streams one entry per cycle through it, reading below while writing above.
// Reset clears the entry count and all control state; table contents are
// not cleared, and no entry's value is used before it is written.
// When the receiver stalls, the result holds in the output register.
module sorted_table_find_swap_or_insert
    import stbl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_found,
    output logic             o_swapped,
    output logic [CNT_W-1:0] o_position,
    output logic             o_overflow,
    output logic [CNT_W-1:0] o_entry_count
);

    t_state   r_state, n_state;
    t_cnt     r_count;
    t_key     r_key;
    t_bound   r_first, r_last;
    t_idx     r_mid;
    t_cnt     r_pos;
    t_cnt     r_idx;
    t_idx     r_widx;
    logic     r_wpend;
    logic     r_found, r_swapped, r_overflow;
    logic     r_out_valid;
    logic     r_out_found, r_out_swapped, r_out_overflow;
    t_cnt     r_out_pos, r_out_count;

    t_ram_ctl ram_ctl;
    t_key     rdata;
    logic     in_accept;
    logic     out_load;

    // search step signals
    logic     cmp_eq, cmp_lt;
    t_bound   n_first, n_last;
    logic     search_more;
    logic [CNT_W+1:0] mid_sum;
    t_idx     n_mid;
    t_idx     start_mid;
    logic     has_succ;
    logic     shift_more;
    logic     full;

    stbl_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_ctl.we),
        .i_waddr(ram_ctl.waddr),
        .i_wdata(ram_ctl.wdata),
        .i_raddr(ram_ctl.raddr),
        .o_rdata(rdata)
    );

    assign in_accept = i_valid && !o_stall;
    assign out_load  = (r_state == ST_DONE) && (!r_out_valid || !i_stall);
    assign full      = (r_count >= t_cnt'(CAPACITY));
    assign start_mid = t_idx'((r_count - t_cnt'(1)) >> 1);

    always_comb begin
        cmp_eq  = (rdata == r_key);
        cmp_lt  = (rdata < r_key);
        n_first = r_first;
        n_last  = r_last;
        if (cmp_lt) begin
            n_first = t_bound'({1'b0, r_mid}) + t_bound'(1);
        end else begin
            n_last = t_bound'({1'b0, r_mid}) - t_bound'(1);
        end
        search_more = !cmp_eq && (n_first <= n_last);
        mid_sum     = {n_first[CNT_W], n_first} + {n_last[CNT_W], n_last};
        n_mid       = mid_sum[IDX_W:1];
        has_succ    = ({1'b0, r_mid} + t_cnt'(1)) < r_count;
        shift_more  = r_idx > r_pos;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (r_count == '0) ? ST_SHIFT : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (cmp_eq) begin
                    n_state = has_succ ? ST_SWAP_RD : ST_DONE;
                end else if (!search_more) begin
                    n_state = full ? ST_DONE : ST_SHIFT;
                end
            end
            ST_SWAP_RD:    n_state = ST_SWAP_WR_LO;
            ST_SWAP_WR_LO: n_state = ST_SWAP_WR_HI;
            ST_SWAP_WR_HI: n_state = ST_DONE;
            ST_SHIFT: begin
                if (!shift_more) begin
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT:     n_state = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    // ram control and input stall
    always_comb begin
        ram_ctl.we    = 1'b0;
        ram_ctl.waddr = r_mid;
        ram_ctl.wdata = rdata;
        ram_ctl.raddr = r_mid;
        o_stall       = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                ram_ctl.raddr = start_mid;
            end
            ST_SEARCH: begin
                ram_ctl.raddr = n_mid;
            end
            ST_SWAP_RD: begin
                ram_ctl.raddr = r_mid + t_idx'(1);
            end
            ST_SWAP_WR_LO: begin
                ram_ctl.we    = 1'b1;
                ram_ctl.waddr = r_mid;
                ram_ctl.wdata = rdata;
            end
            ST_SWAP_WR_HI: begin
                ram_ctl.we    = 1'b1;
                ram_ctl.waddr = r_mid + t_idx'(1);
                ram_ctl.wdata = r_key;
            end
            ST_SHIFT: begin
                ram_ctl.raddr = t_idx'(r_idx - t_cnt'(1));
                ram_ctl.we    = r_wpend;
                ram_ctl.waddr = r_widx;
                ram_ctl.wdata = rdata;
            end
            ST_INSERT: begin
                ram_ctl.we    = 1'b1;
                ram_ctl.waddr = t_idx'(r_pos);
                ram_ctl.wdata = r_key;
            end
            ST_DONE: begin
                ram_ctl.we = 1'b0;
            end
            default: begin
                ram_ctl.we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_INSERT) begin
                r_count <= r_count + t_cnt'(1);
            end
            if (r_state == ST_SHIFT) begin
                r_wpend <= shift_more;
            end else begin
                r_wpend <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    r_key      <= t_key'(i_key);
                    r_first    <= '0;
                    r_last     <= t_bound'({1'b0, r_count}) - t_bound'(1);
                    r_mid      <= start_mid;
                    r_idx      <= r_count;
                    r_pos      <= '0;
                    r_found    <= 1'b0;
                    r_swapped  <= 1'b0;
                    r_overflow <= 1'b0;
                end
            end
            ST_SEARCH: begin
                r_first <= n_first;
                r_last  <= n_last;
                if (cmp_eq) begin
                    r_found   <= 1'b1;
                    r_swapped <= has_succ;
                    r_pos     <= t_cnt'(r_mid);
                end else if (!search_more) begin
                    r_pos      <= t_cnt'(n_first);
                    r_overflow <= full;
                end else begin
                    r_mid <= n_mid;
                end
            end
            ST_SHIFT: begin
                if (shift_more) begin
                    r_widx <= t_idx'(r_idx);
                    r_idx  <= r_idx - t_cnt'(1);
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    r_out_found    <= r_found;
                    r_out_swapped  <= r_swapped;
                    r_out_overflow <= r_overflow;
                    r_out_pos      <= r_pos;
                    r_out_count    <= r_count;
                end
            end
            default: begin
                r_key <= r_key;
            end
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_found       = r_out_found;
    assign o_swapped     = r_out_swapped;
    assign o_overflow    = r_out_overflow;
    assign o_position    = r_out_pos;
    assign o_entry_count = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(CAPACITY))
        else $error("entry count above capacity");

    a_swap_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_swapped |-> o_found && !o_overflow)
        else $error("swap reported without a match");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> !o_found && (o_entry_count == t_cnt'(CAPACITY)))
        else $error("overflow reported on a table that is not full");

    a_insert_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found && !o_overflow |-> o_position < o_entry_count)
        else $error("insert position outside the table");

    a_shift_no_alias: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT) && r_wpend |-> ram_ctl.waddr != ram_ctl.raddr)
        else $error("shift reads the entry it writes");

endmodule

### rtl/stbl_ram.sv
// generic single-clock ram, one write port and one registered read port
module stbl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### bench/sorted_table_checker.sv
`timescale 1ns / 100ps
// checker for the sorted key table: predicts each result and compares it with the block's output
module sorted_table_checker
    import stbl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_key_valid,
    input  logic             i_key_stall,
    input  logic [KEY_W-1:0] i_key,
    input  logic             i_res_valid,
    input  logic             i_res_stall,
    input  logic             i_found,
    input  logic             i_swapped,
    input  logic [CNT_W-1:0] i_position,
    input  logic             i_overflow,
    input  logic [CNT_W-1:0] i_entry_count,
    output int               o_errors,
    output int               o_waiting
);

    typedef struct packed {
        logic found;
        logic swapped;
        t_cnt position;
        logic overflow;
        t_cnt entry_count;
    } t_lookup_result;

    t_key           stored_keys [CAPACITY];
    int             stored_count;
    t_lookup_result expected_results [$];
    int             error_count;

    // search, then swap with the successor or insert in order; updates the table
    function automatic t_lookup_result apply_lookup(input t_key key);
        t_lookup_result r;
        int             lo;
        int             hi;
        int             mid;
        int             i;
        t_key           held;
        r   = '0;
        lo  = 0;
        hi  = stored_count - 1;
        mid = 0;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (stored_keys[mid] == key) begin
                r.found = 1'b1;
                break;
            end else if (stored_keys[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        if (r.found) begin
            r.position = t_cnt'(mid);
            if (mid + 1 < stored_count) begin
                held                 = stored_keys[mid];
                stored_keys[mid]     = stored_keys[mid + 1];
                stored_keys[mid + 1] = held;
                r.swapped            = 1'b1;
            end
        end else begin
            r.position = t_cnt'(hi + 1);
            if (stored_count >= CAPACITY) begin
                r.overflow = 1'b1;
            end else begin
                for (i = stored_count; i > hi + 1; i--)
                    stored_keys[i] = stored_keys[i - 1];
                stored_keys[hi + 1] = key;
                stored_count++;
            end
        end
        r.entry_count = t_cnt'(stored_count);
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (!i_rst_n) begin
            stored_count = 0;
            error_count  = 0;
            expected_results.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no item waiting, expected none got position %0d",
                             $time, i_position);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("found", want.found, i_found);
                    check_field("swapped", want.swapped, i_swapped);
                    check_field("position", want.position, i_position);
                    check_field("overflow", want.overflow, i_overflow);
                    check_field("entry_count", want.entry_count, i_entry_count);
                end
            end
            if (i_key_valid && !i_key_stall)
                expected_results.push_back(apply_lookup(t_key'(i_key)));
        end
        o_errors  <= error_count;
        o_waiting <= expected_results.size();
    end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// top of the sorted key table testbench: clock, reset, key stimulus, result stalls and verdict
module tb
    import stbl_pkg::*;
();

    localparam t_key KEY_MIN     = 32'sh8000_0000;
    localparam t_key KEY_MAX     = 32'sh7FFF_FFFF;
    localparam int   NUM_RANDOM  = 900;
    localparam int   QUIET_FROM  = 800;
    localparam int   HOLD_AT     = 300;
    localparam int   HOLD_CYCLES = 600;
    localparam int   IDLE_LIMIT  = 4000;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic [KEY_W-1:0] i_key   = '0;
    logic             i_stall = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic             o_found;
    logic             o_swapped;
    logic [CNT_W-1:0] o_position;
    logic             o_overflow;
    logic [CNT_W-1:0] o_entry_count;

    int   errors;
    int   waiting;
    int   idle_cycles  = 0;
    bit   hold_off_req = 1'b0;
    bit   stall_bursts = 1'b1;
    t_key key_pool [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sorted_table_find_swap_or_insert DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_swapped     (o_swapped),
        .o_position    (o_position),
        .o_overflow    (o_overflow),
        .o_entry_count (o_entry_count)
    );

    sorted_table_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key_valid   (i_valid),
        .i_key_stall   (o_stall),
        .i_key         (i_key),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_found       (o_found),
        .i_swapped     (o_swapped),
        .i_position    (o_position),
        .i_overflow    (o_overflow),
        .i_entry_count (o_entry_count),
        .o_errors      (errors),
        .o_waiting     (waiting)
    );

    task automatic offer_key(input t_key k, input bit with_gaps);
        i_valid <= 1'b1;
        i_key   <= k;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        key_pool.push_back(k);
        if (with_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11))
                @(posedge i_clk);
        end
    endtask

    // mostly keys already seen or their neighbors, so finds and swaps are frequent
    function automatic t_key pick_key();
        int   sel;
        t_key k;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else if (sel < 55) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)] + $urandom_range(0, 2) - 1;
        end else if (sel < 65) begin
            case ($urandom_range(0, 3))
                0: k = KEY_MIN;
                1: k = KEY_MAX;
                2: k = '0;
                default: k = -32'sd1;
            endcase
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge i_clk);
                i_stall      <= 1'b0;
                hold_off_req = 1'b0;
            end else if (stall_bursts && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 11))
                    @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_key directed_keys [] = '{
            32'sd0, 32'sd0, KEY_MIN, KEY_MAX, KEY_MIN, -32'sd1, KEY_MAX, 32'sd1,
            32'sd2, 32'sh5555_5555, 32'shAAAA_AAAA, -32'sd2, 32'sd100, 32'sd100,
            32'sd99, 32'sd101, KEY_MIN, 32'sd0, -32'sd1, 32'sd2, KEY_MAX
        };
        int n;
        repeat (9)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_keys[j])
            offer_key(directed_keys[j], 1'b1);
        for (n = 0; n < NUM_RANDOM; n++) begin
            if (n == HOLD_AT)
                hold_off_req = 1'b1;
            if (n == QUIET_FROM)
                stall_bursts = 1'b0;
            offer_key(pick_key(), n < QUIET_FROM);
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0)
            @(posedge i_clk);
        repeat (300)
            @(posedge i_clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
rtl/stbl_pkg.sv
rtl/stbl_ram.sv
rtl/sorted_table_find_swap_or_insert.sv
bench/sorted_table_checker.sv
bench/tb.sv
